[design/gregorian_date_calculator_defines.svh]
// Assertion macros used by the date calculator checker.
`ifndef GREGORIAN_DATE_CALCULATOR_DEFINES_SVH
`define GREGORIAN_DATE_CALCULATOR_DEFINES_SVH

// Whenever ante holds, cons must match starting from the same edge.
`define GDC_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// The expression must never be true outside reset.
`define GDC_ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(expr)) \
    else $error(msg);

`endif

[design/gdc_pkg.sv]
// Shared types, constants and calendar tables for the date calculator.
`timescale 1ns / 1ps

package gdc_pkg;

  // Operation codes
  localparam logic [2:0] MODE_NEXT_DAY    = 3'd0;
  localparam logic [2:0] MODE_PREV_DAY    = 3'd1;
  localparam logic [2:0] MODE_NEXT_MONTH  = 3'd2;
  localparam logic [2:0] MODE_DAY_OF_YEAR = 3'd3;
  localparam logic [2:0] MODE_WEEKDAY     = 3'd4;
  localparam logic [2:0] MODE_MONTH_LEN   = 3'd5;
  localparam logic [2:0] MODE_ORD_TO_DATE = 3'd6;

  localparam logic [13:0] YEAR_MAX    = 14'd9999;
  localparam logic [9:0]  ORD_MAX     = 10'd731;
  localparam logic [9:0]  COMMON_YEAR = 10'd365;
  localparam logic [3:0]  LAST_MONTH  = 4'd12;
  localparam logic [4:0]  DEC_LEN     = 5'd31;

  // floor(y / 25) = (y * RECIP25) >> SHIFT25, exact for all 14-bit y
  localparam logic [15:0] RECIP25 = 16'd41944;
  localparam int          SHIFT25 = 20;
  // floor(s / 7) = (s * RECIP7) >> SHIFT7, exact for all 15-bit s
  localparam logic [15:0] RECIP7  = 16'd37450;
  localparam int          SHIFT7  = 18;

  localparam logic [13:0] CENTURY      = 14'd100;
  localparam logic [13:0] QUAD_CENTURY = 14'd400;

  // Register stages from accepted item to result strobe
  localparam int PIPE_DEPTH = 6;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
  } md_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                            len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:         len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
      4'd10, 4'd12:                    len = 5'd31;
      default:                         len = 5'd0;
    endcase
    return len;
  endfunction

  // Days of the year that lie before the first of month m
  function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    unique case (m)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && m > 4'd2 && m <= LAST_MONTH) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  // (31 * mm) / 12 of the weekday formula, mm being the March-based month
  function automatic logic [4:0] wd_offset(input logic [3:0] m);
    logic [4:0] off;
    unique case (m)
      4'd1:    off = 5'd28;
      4'd2:    off = 5'd31;
      4'd3:    off = 5'd2;
      4'd4:    off = 5'd5;
      4'd5:    off = 5'd7;
      4'd6:    off = 5'd10;
      4'd7:    off = 5'd12;
      4'd8:    off = 5'd15;
      4'd9:    off = 5'd18;
      4'd10:   off = 5'd20;
      4'd11:   off = 5'd23;
      4'd12:   off = 5'd25;
      default: off = 5'd0;
    endcase
    return off;
  endfunction

endpackage

[design/gdc_month_search.sv]
// Splits a day number within one year into month and day of month.
`timescale 1ns / 1ps

module gdc_month_search (
  input  logic         [8:0] rem,
  input  logic               leap,
  output gdc_pkg::md_t       md
);
  import gdc_pkg::*;

  logic [3:0] cnt;
  logic [3:0] month;
  logic [8:0] month_start;

  always_comb begin
    cnt = '0;
    // count the month ends that the day number lies past
    for (int k = 1; k < 12; k++) begin
      if (rem > days_before(4'(k + 1), leap)) begin
        cnt = cnt + 4'd1;
      end
    end
    month       = cnt + 4'd1;
    month_start = days_before(month, leap);
    md.month    = month;
    md.day      = 5'(rem - month_start);
  end

endmodule

[design/gregorian_date_calculator.sv]
// Top level of the Gregorian date calculator pipeline.
`timescale 1ns / 1ps

// Channel   Signals                                          Transfer
// --------  -----------------------------------------------  --------------------------
// command   start, busy, mode, day_in, month_in, year_in,    start high while busy low
//           ordinal_in
// result    done, day_out, month_out, year_out, number_out,  done high, one cycle only
//           leap_out, valid_out
//
// Every command gives one result; the six register stages (input, divide by 25, century
// remainders, weekday sum, date select, weekday remainder) lie between its transfer and
// that result. A command transfers every cycle; busy is high only while rst is high.
// Synchronous reset empties the pipeline and drops items in flight. The receiver cannot
// stall: each result shows for one cycle and is gone.

module gregorian_date_calculator (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [4:0]  day_in,
  input  logic [3:0]  month_in,
  input  logic [13:0] year_in,
  input  logic [9:0]  ordinal_in,
  output logic        done,
  output logic [4:0]  day_out,
  output logic [3:0]  month_out,
  output logic [13:0] year_out,
  output logic [8:0]  number_out,
  output logic        leap_out,
  output logic        valid_out
);
  import gdc_pkg::*;

  logic accept;

  // Stage valid bits
  logic v0, v1, v2, v3, v4;

  // Stage 0: captured command
  logic [2:0]  s0_mode;
  logic [4:0]  s0_day;
  logic [3:0]  s0_month;
  logic [13:0] s0_year;
  logic [9:0]  s0_ord;

  // Stage 1: year / 25
  logic [2:0]  s1_mode;
  logic [4:0]  s1_day;
  logic [3:0]  s1_month;
  logic [13:0] s1_year;
  logic [9:0]  s1_ord;
  logic [9:0]  s1_q25;
  logic [29:0] prod25;

  // Stage 2: century quotients, remainders and leap flags
  logic [2:0]  s2_mode;
  logic [4:0]  s2_day;
  logic [3:0]  s2_month;
  logic [13:0] s2_year;
  logic [9:0]  s2_ord;
  logic [7:0]  s2_q100;
  logic [5:0]  s2_q400;
  logic        s2_r100_zero;
  logic        s2_r400_zero;
  logic        s2_leap;
  logic        s2_leap_next;
  logic [7:0]  q100;
  logic [5:0]  q400;
  logic [13:0] r100;
  logic [13:0] r400;

  // Stage 3: weekday sum and ordinal split by year
  logic [2:0]  s3_mode;
  logic [4:0]  s3_day;
  logic [3:0]  s3_month;
  logic [13:0] s3_year;
  logic        s3_leap;
  logic        s3_leap_c;
  logic [14:0] s3_sum;
  logic        s3_year_ok;
  logic        s3_ord_ok;
  logic [8:0]  s3_rem;
  logic [13:0] s3_cy;
  logic        jan_feb;
  logic [13:0] yy;
  logic [14:0] sum;
  logic [9:0]  yl0;
  logic [9:0]  yl1;
  logic        roll;
  logic [9:0]  ord_less;

  // Stage 4: selected date, weekday quotient
  logic [4:0]  s4_day;
  logic [3:0]  s4_month;
  logic [13:0] s4_year;
  logic [8:0]  s4_num;
  logic        s4_wd;
  logic        s4_ok;
  logic        s4_leap;
  logic [14:0] s4_sum;
  logic [12:0] s4_q7;
  logic [30:0] prod7;
  md_t         md;
  logic [4:0]  ml_cur;
  logic [4:0]  ml_prev;
  logic [4:0]  ml_next;
  logic        last_m;
  logic [3:0]  nm;
  logic        date_ok;
  logic [4:0]  rd;
  logic [3:0]  rm;
  logic [13:0] ry;
  logic [8:0]  num;
  logic        is_wd;
  logic        ok;

  // Output stage
  logic [14:0] r7;

  assign busy   = rst;
  assign accept = start && !busy;

  // Hold the valid bits; reset drops everything in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      done <= 1'b0;
    end else begin
      v0   <= accept;
      v1   <= v0;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      done <= v4;
    end
  end

  // Stage 0: capture the command on transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      s0_mode  <= mode;
      s0_day   <= day_in;
      s0_month <= month_in;
      s0_year  <= year_in;
      s0_ord   <= ordinal_in;
    end
  end

  // Stage 1: divide the year by 25 with a reciprocal multiply.
  assign prod25 = 30'(s0_year) * 30'(RECIP25);

  always_ff @(posedge clk) begin
    s1_mode  <= s0_mode;
    s1_day   <= s0_day;
    s1_month <= s0_month;
    s1_year  <= s0_year;
    s1_ord   <= s0_ord;
    s1_q25   <= prod25[SHIFT25 +: 10];
  end

  // Stage 2: y/100 and y/400 follow from y/25 by shifts; leap flags for y and y+1.
  assign q100 = s1_q25[9:2];
  assign q400 = s1_q25[9:4];
  assign r100 = s1_year - 14'(q100) * CENTURY;
  assign r400 = s1_year - 14'(q400) * QUAD_CENTURY;

  always_ff @(posedge clk) begin
    s2_mode      <= s1_mode;
    s2_day       <= s1_day;
    s2_month     <= s1_month;
    s2_year      <= s1_year;
    s2_ord       <= s1_ord;
    s2_q100      <= q100;
    s2_q400      <= q400;
    s2_r100_zero <= (r100 == 14'd0);
    s2_r400_zero <= (r400 == 14'd0);
    s2_leap      <= (r400 == 14'd0) || (s1_year[1:0] == 2'd0 && r100 != 14'd0);
    s2_leap_next <= (r400 == QUAD_CENTURY - 14'd1) ||
                    (s1_year[1:0] == 2'd3 && r100 != CENTURY - 14'd1);
  end

  // Stage 3: weekday sum over the March-based year; split the ordinal by year.
  always_comb begin
    // January and February count as months of the previous year
    jan_feb  = (s2_month == 4'd1) || (s2_month == 4'd2);
    yy       = s2_year - 14'(jan_feb);
    sum      = 15'(s2_day) + 15'(yy) + 15'(yy >> 2)
             - 15'(s2_q100) + 15'(jan_feb && s2_r100_zero)
             + 15'(s2_q400) - 15'(jan_feb && s2_r400_zero)
             + 15'(wd_offset(s2_month));
    yl0      = COMMON_YEAR + 10'(s2_leap);
    yl1      = COMMON_YEAR + 10'(s2_leap_next);
    roll     = s2_ord > yl0;
    ord_less = s2_ord - yl0;
  end

  always_ff @(posedge clk) begin
    s3_mode    <= s2_mode;
    s3_day     <= s2_day;
    s3_month   <= s2_month;
    s3_year    <= s2_year;
    s3_leap    <= s2_leap;
    s3_leap_c  <= roll ? s2_leap_next : s2_leap;
    s3_sum     <= sum;
    s3_year_ok <= (s2_year != 14'd0) && (s2_year <= YEAR_MAX);
    s3_ord_ok  <= (s2_ord != 10'd0) && (s2_ord <= ORD_MAX) &&
                  (11'(s2_ord) <= 11'(yl0) + 11'(yl1));
    s3_rem     <= roll ? ord_less[8:0] : s2_ord[8:0];
    s3_cy      <= s2_year + 14'(roll);
  end

  // Stage 4: resolve the date operations; start the weekday remainder.
  gdc_month_search u_month_search (
    .rem  (s3_rem),
    .leap (s3_leap_c),
    .md   (md)
  );

  assign prod7 = 31'(s3_sum) * 31'(RECIP7);

  always_comb begin
    ml_cur  = month_len(s3_month, s3_leap);
    ml_prev = month_len(s3_month - 4'd1, s3_leap);
    last_m  = (s3_month == LAST_MONTH);
    nm      = last_m ? 4'd1 : s3_month + 4'd1;
    // January of the next year has the same length regardless of leap
    ml_next = month_len(nm, s3_leap);
    date_ok = s3_year_ok && (s3_month != 4'd0) && (s3_month <= LAST_MONTH) &&
              (s3_day != 5'd0) && (s3_day <= ml_cur);
    rd      = s3_day;
    rm      = s3_month;
    ry      = s3_year;
    num     = '0;
    is_wd   = 1'b0;
    ok      = 1'b0;
    unique case (s3_mode)
      MODE_NEXT_DAY: begin
        ok = date_ok;
        if (s3_day == ml_cur) begin
          rd = 5'd1;
          rm = nm;
          ry = s3_year + 14'(last_m);
        end else begin
          rd = s3_day + 5'd1;
        end
      end
      MODE_PREV_DAY: begin
        ok = date_ok;
        if (s3_day == 5'd1) begin
          if (s3_month == 4'd1) begin
            rm = LAST_MONTH;
            rd = DEC_LEN;
            ry = s3_year - 14'd1;
          end else begin
            rm = s3_month - 4'd1;
            rd = ml_prev;
          end
        end else begin
          rd = s3_day - 5'd1;
        end
      end
      MODE_NEXT_MONTH: begin
        ok = date_ok;
        rm = nm;
        ry = s3_year + 14'(last_m);
        rd = (s3_day > ml_next) ? ml_next : s3_day;
      end
      MODE_DAY_OF_YEAR: begin
        ok  = date_ok;
        num = days_before(s3_month, s3_leap) + 9'(s3_day);
      end
      MODE_WEEKDAY: begin
        ok    = date_ok;
        is_wd = 1'b1;
      end
      MODE_MONTH_LEN: begin
        ok  = date_ok;
        num = 9'(ml_cur);
      end
      MODE_ORD_TO_DATE: begin
        ok = s3_year_ok && s3_ord_ok;
        rd = md.day;
        rm = md.month;
        ry = s3_cy;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    // Drop results that leave the supported year range.
    if (ry == 14'd0 || ry > YEAR_MAX) begin
      ok = 1'b0;
    end
    // Echo the input date on any failure.
    if (!ok) begin
      rd    = s3_day;
      rm    = s3_month;
      ry    = s3_year;
      num   = '0;
      is_wd = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    s4_day   <= rd;
    s4_month <= rm;
    s4_year  <= ry;
    s4_num   <= num;
    s4_wd    <= is_wd;
    s4_ok    <= ok;
    s4_leap  <= s3_leap;
    s4_sum   <= s3_sum;
    s4_q7    <= prod7[SHIFT7 +: 13];
  end

  // Output stage: weekday remainder, then present the result for one cycle.
  assign r7 = s4_sum - ((15'(s4_q7) << 3) - 15'(s4_q7));

  always_ff @(posedge clk) begin
    day_out    <= s4_day;
    month_out  <= s4_month;
    year_out   <= s4_year;
    number_out <= s4_wd ? r7[8:0] : s4_num;
    leap_out   <= s4_leap;
    valid_out  <= s4_ok;
  end

endmodule

[design/gdc_checker.sv]
// Port-level checker for the date calculator and its bind.
`timescale 1ns / 1ps
`include "gregorian_date_calculator_defines.svh"

module gdc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [2:0]  mode,
  input logic [4:0]  day_in,
  input logic [3:0]  month_in,
  input logic [13:0] year_in,
  input logic [9:0]  ordinal_in,
  input logic        done,
  input logic [4:0]  day_out,
  input logic [3:0]  month_out,
  input logic [13:0] year_out,
  input logic [8:0]  number_out,
  input logic        leap_out,
  input logic        valid_out
);
  import gdc_pkg::*;

  // Every transfer yields its result after a fixed latency, and nothing else does.
  `GDC_ASSERT_IMPLY(a_result_follows, clk, rst, start && !busy, ##PIPE_DEPTH done, "result missing after transfer")
  `GDC_ASSERT_NEVER(a_no_spurious, clk, rst, done && !$past(start && !busy, PIPE_DEPTH), "result without a transfer")

  // A failed item echoes its date and clears the number.
  `GDC_ASSERT_IMPLY(a_echo_invalid, clk, rst, done && !valid_out, day_out == $past(day_in, PIPE_DEPTH) && month_out == $past(month_in, PIPE_DEPTH) && year_out == $past(year_in, PIPE_DEPTH) && number_out == 9'd0, "invalid result does not echo input")

  // Date operations carry no number.
  `GDC_ASSERT_IMPLY(a_date_no_number, clk, rst, done && ($past(mode, PIPE_DEPTH) == MODE_NEXT_DAY || $past(mode, PIPE_DEPTH) == MODE_PREV_DAY || $past(mode, PIPE_DEPTH) == MODE_NEXT_MONTH || $past(mode, PIPE_DEPTH) == MODE_ORD_TO_DATE), number_out == 9'd0, "date operation returned a number")

  // Number operations leave the date as given.
  `GDC_ASSERT_IMPLY(a_number_keeps_date, clk, rst, done && ($past(mode, PIPE_DEPTH) == MODE_DAY_OF_YEAR || $past(mode, PIPE_DEPTH) == MODE_WEEKDAY || $past(mode, PIPE_DEPTH) == MODE_MONTH_LEN), day_out == $past(day_in, PIPE_DEPTH) && month_out == $past(month_in, PIPE_DEPTH) && year_out == $past(year_in, PIPE_DEPTH), "number operation changed the date")

endmodule

bind gregorian_date_calculator gdc_checker u_gdc_checker (.*);

[sim/testbench.sv]
// Self-checking testbench for the Gregorian date calculator.
`timescale 1ns / 1ps

module testbench;
  import gdc_pkg::*;

  // Mode code the block leaves unused; it must come back invalid.
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 2000;
  localparam int MAX_GAP = 12;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [2:0]  mode;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [9:0]  ordinal;
  } date_cmd_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [8:0]  number;
    logic        leap;
    logic        valid;
  } date_res_t;

  // Expected results of accepted commands, oldest first, and the calendar
  // arithmetic that produces them.
  class date_result_board;
    date_res_t pending_dates[$];
    int unsigned mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    function bit is_leap_year(int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function int unsigned days_in_month(int unsigned m, int unsigned y);
      case (m)
        2:                     return is_leap_year(y) ? 29 : 28;
        4, 6, 9, 11:           return 30;
        1, 3, 5, 7, 8, 10, 12: return 31;
        default:               return 0;
      endcase
    endfunction

    function int unsigned days_in_year(int unsigned y);
      return is_leap_year(y) ? 366 : 365;
    endfunction

    // Zeller-style weekday, 0 is Sunday; January and February count as
    // months 11 and 12 of the year before.
    function int unsigned day_of_week(int unsigned d, int unsigned m, int unsigned y);
      int unsigned a;
      int unsigned yy;
      int unsigned mm;
      a = (14 - m) / 12;
      yy = y - a;
      mm = m + 12 * a - 2;
      return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
    endfunction

    function date_res_t calc_date_result(date_cmd_t c);
      int unsigned d, m, y, o;
      int unsigned rd, rm, ry, num, rem, cy, cm, ml, k;
      bit ok, year_ok, date_ok;
      date_res_t r;
      d = c.day;
      m = c.month;
      y = c.year;
      o = c.ordinal;
      rd = d;
      rm = m;
      ry = y;
      num = 0;
      ok = 1'b0;
      year_ok = (y >= 1) && (y <= YEAR_MAX);
      date_ok = year_ok && (m >= 1) && (m <= LAST_MONTH) && (d >= 1) &&
                (d <= days_in_month(m, y));
      if (c.mode <= MODE_MONTH_LEN && date_ok) begin
        ok = 1'b1;
        case (c.mode)
          MODE_NEXT_DAY: begin
            if (d == days_in_month(m, y)) begin
              rd = 1;
              if (m == LAST_MONTH) begin
                rm = 1;
                ry = y + 1;
              end else begin
                rm = m + 1;
              end
            end else begin
              rd = d + 1;
            end
          end
          MODE_PREV_DAY: begin
            if (d == 1) begin
              if (m == 1) begin
                rm = LAST_MONTH;
                rd = DEC_LEN;
                ry = y - 1;
              end else begin
                rm = m - 1;
                rd = days_in_month(rm, y);
              end
            end else begin
              rd = d - 1;
            end
          end
          MODE_NEXT_MONTH: begin
            if (m == LAST_MONTH) begin
              rm = 1;
              ry = y + 1;
            end else begin
              rm = m + 1;
            end
            ml = days_in_month(rm, ry);
            rd = (d > ml) ? ml : d;
          end
          MODE_DAY_OF_YEAR: begin
            num = d;
            for (k = 1; k < m; k++) begin
              num += days_in_month(k, y);
            end
          end
          MODE_WEEKDAY: begin
            num = day_of_week(d, m, y);
          end
          default: begin
            num = days_in_month(m, y);
          end
        endcase
        if (ry < 1 || ry > YEAR_MAX) begin
          ok = 1'b0;
        end
      end else if (c.mode == MODE_ORD_TO_DATE && year_ok && o >= 1 && o <= ORD_MAX &&
                   o <= days_in_year(y) + days_in_year(y + 1)) begin
        rem = o;
        cy = y;
        cm = 1;
        if (rem > days_in_year(cy)) begin
          rem -= days_in_year(cy);
          cy++;
        end
        while (cm < LAST_MONTH && rem > days_in_month(cm, cy)) begin
          rem -= days_in_month(cm, cy);
          cm++;
        end
        rd = rem;
        rm = cm;
        ry = cy;
        ok = (cy <= YEAR_MAX);
      end
      if (!ok) begin
        rd = d;
        rm = m;
        ry = y;
        num = 0;
      end
      r.day = rd[4:0];
      r.month = rm[3:0];
      r.year = ry[13:0];
      r.number = num[8:0];
      r.leap = is_leap_year(y);
      r.valid = ok;
      return r;
    endfunction

    function void note_command(date_cmd_t c);
      pending_dates.push_back(calc_date_result(c));
    endfunction

    function void check_result(date_res_t got);
      date_res_t exp_res;
      if (pending_dates.size() == 0) begin
        $error("result with no command outstanding");
        mismatch_count++;
        return;
      end
      exp_res = pending_dates.pop_front();
      if (got.day !== exp_res.day) begin
        $error("day_out: expected %0d, actual %0d", exp_res.day, got.day);
        mismatch_count++;
      end
      if (got.month !== exp_res.month) begin
        $error("month_out: expected %0d, actual %0d", exp_res.month, got.month);
        mismatch_count++;
      end
      if (got.year !== exp_res.year) begin
        $error("year_out: expected %0d, actual %0d", exp_res.year, got.year);
        mismatch_count++;
      end
      if (got.number !== exp_res.number) begin
        $error("number_out: expected %0d, actual %0d", exp_res.number, got.number);
        mismatch_count++;
      end
      if (got.leap !== exp_res.leap) begin
        $error("leap_out: expected %0d, actual %0d", exp_res.leap, got.leap);
        mismatch_count++;
      end
      if (got.valid !== exp_res.valid) begin
        $error("valid_out: expected %0d, actual %0d", exp_res.valid, got.valid);
        mismatch_count++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  mode = '0;
  logic [4:0]  day_in = '0;
  logic [3:0]  month_in = '0;
  logic [13:0] year_in = '0;
  logic [9:0]  ordinal_in = '0;
  logic        done;
  logic [4:0]  day_out;
  logic [3:0]  month_out;
  logic [13:0] year_out;
  logic [8:0]  number_out;
  logic        leap_out;
  logic        valid_out;

  date_result_board board;
  int unsigned cycle_count = 0;

  gregorian_date_calculator i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .day_in     (day_in),
    .month_in   (month_in),
    .year_in    (year_in),
    .ordinal_in (ordinal_in),
    .done       (done),
    .day_out    (day_out),
    .month_out  (month_out),
    .year_out   (year_out),
    .number_out (number_out),
    .leap_out   (leap_out),
    .valid_out  (valid_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case a transfer or a result never comes.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Note each command transfer and check each result strobe at the edge that ends it.
  always @(posedge clk) begin
    date_cmd_t cmd;
    date_res_t res;
    if (!rst) begin
      if (start && !busy) begin
        cmd.mode = mode;
        cmd.day = day_in;
        cmd.month = month_in;
        cmd.year = year_in;
        cmd.ordinal = ordinal_in;
        board.note_command(cmd);
      end
      if (done) begin
        res.day = day_out;
        res.month = month_out;
        res.year = year_out;
        res.number = number_out;
        res.leap = leap_out;
        res.valid = valid_out;
        board.check_result(res);
      end
    end
  end

  // Present one command from the falling edge, hold it until it transfers,
  // then idle for the given number of cycles.
  task automatic send_command(input date_cmd_t c, input int unsigned gap);
    @(negedge clk);
    mode = c.mode;
    day_in = c.day;
    month_in = c.month;
    year_in = c.year;
    ordinal_in = c.ordinal;
    start = 1'b1;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_fields(input logic [2:0] m_code, input int unsigned d,
                             input int unsigned m, input int unsigned y,
                             input int unsigned o);
    date_cmd_t c;
    c.mode = m_code;
    c.day = d[4:0];
    c.month = m[3:0];
    c.year = y[13:0];
    c.ordinal = o[9:0];
    send_command(c, $urandom_range(0, MAX_GAP));
  endtask

  // Mostly well-formed dates, weighted toward month starts and ends, century
  // years and the edges of the year range; the rest is out-of-range noise.
  function automatic date_cmd_t random_command();
    date_cmd_t c;
    int unsigned sel, y, m, len;
    sel = $urandom_range(0, 99);
    c.mode = (sel < 3) ? MODE_UNUSED : 3'($urandom_range(0, 6));
    sel = $urandom_range(0, 99);
    if (sel < 62) begin
      y = $urandom_range(1, 9999);
    end else if (sel < 74) begin
      y = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(9997, 9999);
    end else if (sel < 88) begin
      y = $urandom_range(1, 99) * 100;
    end else begin
      y = $urandom_range(0, 16383);
    end
    c.year = y[13:0];
    m = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 12) : $urandom_range(0, 15);
    c.month = m[3:0];
    len = board.days_in_month(m, y);
    sel = $urandom_range(0, 99);
    if (len == 0 || sel >= 88) begin
      c.day = 5'($urandom_range(0, 31));
    end else if (sel < 30) begin
      c.day = len[4:0];
    end else if (sel < 45) begin
      c.day = 5'd1;
    end else begin
      c.day = 5'($urandom_range(1, len));
    end
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      c.ordinal = 10'($urandom_range(1, 731));
    end else if (sel < 60) begin
      c.ordinal = 10'($urandom_range(358, 372));
    end else if (sel < 80) begin
      c.ordinal = 10'($urandom_range(725, 735));
    end else if (sel < 88) begin
      c.ordinal = 10'($urandom_range(1, 62));
    end else begin
      c.ordinal = 10'($urandom_range(0, 1023));
    end
    return c;
  endfunction

  initial begin
    int unsigned n;
    int unsigned gap;
    board = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corners: range edges, month and year rollovers, leap rules,
    // mode six roll-over and its ignored date, bad fields and the unused mode.
    send_fields(MODE_NEXT_DAY, 31, 12, 9999, 0);
    send_fields(MODE_PREV_DAY, 1, 1, 1, 0);
    send_fields(MODE_NEXT_MONTH, 15, 12, 9999, 0);
    send_fields(MODE_NEXT_DAY, 28, 2, 2000, 0);
    send_fields(MODE_NEXT_DAY, 28, 2, 1900, 0);
    send_fields(MODE_NEXT_DAY, 31, 12, 2023, 0);
    send_fields(MODE_PREV_DAY, 1, 3, 2024, 0);
    send_fields(MODE_PREV_DAY, 1, 1, 2000, 0);
    send_fields(MODE_NEXT_MONTH, 31, 1, 2023, 0);
    send_fields(MODE_NEXT_MONTH, 31, 1, 2024, 0);
    send_fields(MODE_DAY_OF_YEAR, 31, 12, 2024, 0);
    send_fields(MODE_WEEKDAY, 1, 1, 1, 0);
    send_fields(MODE_WEEKDAY, 31, 12, 9999, 0);
    send_fields(MODE_MONTH_LEN, 1, 2, 2100, 0);
    send_fields(MODE_ORD_TO_DATE, 0, 0, 1, 1);
    send_fields(MODE_ORD_TO_DATE, 31, 15, 2023, 731);
    send_fields(MODE_ORD_TO_DATE, 1, 1, 2022, 731);
    send_fields(MODE_ORD_TO_DATE, 1, 1, 2024, 0);
    send_fields(MODE_ORD_TO_DATE, 1, 1, 2024, 1023);
    send_fields(MODE_ORD_TO_DATE, 1, 1, 9999, 400);
    send_fields(MODE_UNUSED, 10, 6, 2020, 5);
    send_fields(MODE_NEXT_DAY, 0, 6, 2020, 0);
    send_fields(MODE_PREV_DAY, 31, 15, 16383, 1023);
    send_fields(MODE_DAY_OF_YEAR, 15, 0, 0, 0);
    send_fields(MODE_MONTH_LEN, 31, 4, 2021, 0);

    // Random traffic; every fourth stretch of 150 commands runs back to back.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      gap = ((n / 150) % 4 == 0) ? 0 : $urandom_range(0, MAX_GAP);
      send_command(random_command(), gap);
    end
    @(negedge clk);
    start = 1'b0;

    // Drain the pipeline, then watch a little longer for stray strobes.
    while (board.pending_dates.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (board.mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
